FILE: hdl/tsat_pkg.sv
`timescale 1ns / 1ps

package tsat_pkg;

	// Field widths of the request and result beats.
	localparam int FUNC_W     = 2;
	localparam int NODE_W     = 8;
	localparam int QUERY_W    = 8;
	localparam int SLOT_RES_W = 5;
	localparam int ADDR_RES_W = 8;

	// Default table geometry.
	localparam int DEF_SLOTS      = 16;
	localparam int DEF_ADDR_WIDTH = 8;

	// Request operation codes.
	localparam logic [FUNC_W-1:0] FUNC_ATTACH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	// Control strobes from the sequencer to the table storage.
	typedef struct packed {
		logic wr_en;
		logic clr;
	} tsat_tbl_ctrl_t;

	// Slot numbers count from one; the result field keeps only its low bits.
	function automatic logic [SLOT_RES_W-1:0] slot_num(input logic [7:0] idx);
		logic [8:0] sum;
		sum = {1'b0, idx} + 9'd1;
		return sum[SLOT_RES_W-1:0];
	endfunction

endpackage

FILE: hdl/tsat_table.sv
`timescale 1ns / 1ps

module tsat_table import tsat_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
	localparam int IDXW      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsat_tbl_ctrl_t        ctrl,
	input  logic [IDXW-1:0]       wr_idx,
	input  logic [ADDR_WIDTH-1:0] wr_data,
	input  logic [IDXW-1:0]       rd_idx,
	output logic [ADDR_WIDTH-1:0] rd_data
);

	logic [ADDR_WIDTH-1:0] mem [SLOTS];
	logic [SLOTS-1:0]      vld_q;
	logic [ADDR_WIDTH-1:0] mem_rd_q;
	logic                  vld_rd_q;

	// Address storage, one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		mem_rd_q <= mem[rd_idx];
	end

	// Per-slot valid bits; a slot that is not valid reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				vld_q <= '0;
			end else if (ctrl.wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			vld_rd_q <= vld_q[rd_idx];
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule

FILE: hdl/tsat_seq.sv
`timescale 1ns / 1ps

module tsat_seq import tsat_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
	localparam int IDXW      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [FUNC_W-1:0]     func,
	input  logic [ADDR_WIDTH-1:0] node_addr,
	input  logic [QUERY_W-1:0]    slot_query,
	output logic                  idle,
	output logic                  done,
	input  logic                  take,
	output logic [SLOT_RES_W-1:0] slot_res,
	output logic [ADDR_RES_W-1:0] addr_res,
	output tsat_tbl_ctrl_t        tbl_ctrl,
	output logic [IDXW-1:0]       rd_idx,
	input  logic [ADDR_WIDTH-1:0] rd_data,
	output logic [IDXW-1:0]       wr_idx,
	output logic [ADDR_WIDTH-1:0] wr_data
);

	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN     = 3'd1;
	localparam logic [2:0] ST_RD_ISSUE = 3'd2;
	localparam logic [2:0] ST_RD_DATA  = 3'd3;
	localparam logic [2:0] ST_CLR      = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;

	logic [2:0]            state_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [QUERY_W-1:0]    query_q;
	logic [IDXW-1:0]       issue_idx_q;
	logic                  issuing_q;
	logic [IDXW-1:0]       cmp_idx_s1;
	logic                  cmp_vld_s1;
	logic                  have_free_q;
	logic [IDXW-1:0]       free_idx_q;
	logic [SLOT_RES_W-1:0] slot_res_q;
	logic [ADDR_RES_W-1:0] addr_res_q;

	logic                  in_scan;
	logic                  hit;
	logic                  cur_empty;
	logic                  last;
	logic                  free_any;
	logic [IDXW-1:0]       free_sel;
	logic [QUERY_W-1:0]    query_m1;
	logic                  query_ok;

	// Shared compare unit: one stored entry against the request address per cycle.
	always_comb begin
		in_scan   = (state_q == ST_SCAN);
		hit       = cmp_vld_s1 && (rd_data == addr_q);
		cur_empty = cmp_vld_s1 && (rd_data == '0);
		last      = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
		free_any  = have_free_q || cur_empty;
		free_sel  = have_free_q ? free_idx_q : cmp_idx_s1;
		query_m1  = query_q - 8'd1;
		query_ok  = (slot_query != '0) && (32'(slot_query) <= SLOTS);
	end

	// Table port drive.
	assign rd_idx         = in_scan ? issue_idx_q : query_m1[IDXW-1:0];
	assign wr_idx         = free_sel;
	assign wr_data        = addr_q;
	assign tbl_ctrl.wr_en = in_scan && last && !hit && free_any;
	assign tbl_ctrl.clr   = (state_q == ST_CLR);

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			query_q     <= '0;
			issue_idx_q <= '0;
			issuing_q   <= 1'b0;
			cmp_idx_s1  <= '0;
			cmp_vld_s1  <= 1'b0;
			have_free_q <= 1'b0;
			free_idx_q  <= '0;
			slot_res_q  <= '0;
			addr_res_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					if (start) begin
						addr_q      <= node_addr;
						query_q     <= slot_query;
						slot_res_q  <= '0;
						addr_res_q  <= '0;
						issue_idx_q <= '0;
						issuing_q   <= 1'b0;
						have_free_q <= 1'b0;
						case (func)
							FUNC_ATTACH: begin
								issuing_q <= 1'b1;
								state_q   <= ST_SCAN;
							end
							FUNC_READ: begin
								state_q <= query_ok ? ST_RD_ISSUE : ST_DONE;
							end
							FUNC_CLEAR: begin
								state_q <= ST_CLR;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Issue side: one table read per cycle.
					cmp_vld_s1 <= issuing_q;
					cmp_idx_s1 <= issue_idx_q;
					if (issuing_q) begin
						if (issue_idx_q == LAST_IDX) begin
							issuing_q <= 1'b0;
						end else begin
							issue_idx_q <= issue_idx_q + 1'b1;
						end
					end
					// Compare side: remember the first empty slot.
					if (cur_empty && !have_free_q) begin
						have_free_q <= 1'b1;
						free_idx_q  <= cmp_idx_s1;
					end
					if (hit) begin
						slot_res_q <= slot_num(8'(cmp_idx_s1));
						issuing_q  <= 1'b0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_DONE;
					end else if (last) begin
						slot_res_q <= free_any ? slot_num(8'(free_sel)) : '0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					addr_res_q <= ADDR_RES_W'(rd_data);
					state_q    <= ST_DONE;
				end
				ST_CLR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle     = (state_q == ST_IDLE);
	assign done     = (state_q == ST_DONE);
	assign slot_res = slot_res_q;
	assign addr_res = addr_res_q;

endmodule

FILE: hdl/tdma_slot_assign_table.sv
`timescale 1ns / 1ps

// TDMA slot assignment table.
// Requests arrive as beats on the in_valid/in_ready channel (func, node_addr,
// slot_query); each request gives exactly one result beat on the
// out_valid/out_ready channel (slot_result, addr_result).
// An attach scans the table through the single compare unit, one slot per
// cycle out of the registered read port, and stops at the first match. A read
// issues the table read and then captures the data; a clear drops every valid
// bit; an unused code goes straight to the result.
// The block handles one request at a time: in_ready is low from the accept
// until the result has moved into the output register.
// The output register lets the next request be accepted while a result still
// waits; if the receiver stalls, a second finished result is held inside the
// sequencer and no further request is accepted until out_ready returns.
// Reset clears the per-slot valid bits at once, so the table comes up empty
// with no clearing pass, and drops any pending result.

module tdma_slot_assign_table import tsat_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FUNC_W-1:0]     func,
	input  logic [NODE_W-1:0]     node_addr,
	input  logic [QUERY_W-1:0]    slot_query,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SLOT_RES_W-1:0] slot_result,
	output logic [ADDR_RES_W-1:0] addr_result
);

	localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	tsat_tbl_ctrl_t        tbl_ctrl;
	logic [IDXW-1:0]       rd_idx;
	logic [IDXW-1:0]       wr_idx;
	logic [ADDR_WIDTH-1:0] rd_data;
	logic [ADDR_WIDTH-1:0] wr_data;
	logic                  seq_idle;
	logic                  seq_done;
	logic                  take;
	logic [SLOT_RES_W-1:0] seq_slot_res;
	logic [ADDR_RES_W-1:0] seq_addr_res;
	logic                  out_valid_q;
	logic [SLOT_RES_W-1:0] slot_result_q;
	logic [ADDR_RES_W-1:0] addr_result_q;

	tsat_table #(
		.SLOTS      (SLOTS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (tbl_ctrl),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	tsat_seq #(
		.SLOTS      (SLOTS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && in_ready),
		.func       (func),
		.node_addr  (node_addr[ADDR_WIDTH-1:0]),
		.slot_query (slot_query),
		.idle       (seq_idle),
		.done       (seq_done),
		.take       (take),
		.slot_res   (seq_slot_res),
		.addr_res   (seq_addr_res),
		.tbl_ctrl   (tbl_ctrl),
		.rd_idx     (rd_idx),
		.rd_data    (rd_data),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data)
	);

	assign in_ready = seq_idle;

	// Output register: loads a finished result whenever it is empty or draining.
	assign take = seq_done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_result_q <= seq_slot_res;
			addr_result_q <= seq_addr_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_result = slot_result_q;
	assign addr_result = addr_result_q;

	// The block takes no second request right after accepting one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while a request was in progress");

	// A result carries a slot number or an address, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((slot_result == '0) || (addr_result == '0)))
		else $error("result has both slot and address set");

	// Table writes and clears happen only while a request is being worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(tbl_ctrl.wr_en || tbl_ctrl.clr) |-> !in_ready)
		else $error("table modified while idle");

	// A returned slot number never exceeds the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(slot_result) <= SLOTS))
		else $error("slot number beyond table size");

endmodule
